@@ hw/rtl/mqf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mqf_pkg;

  // Sizing of the shared store
  localparam int MAX_QUEUES  = 4;
  localparam int QUEUE_DEPTH = 16;
  localparam int DATA_BITS   = 32;

  localparam int QSEL_BITS   = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;
  localparam int PTR_BITS    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int COUNT_BITS  = $clog2(QUEUE_DEPTH + 1);
  localparam int STORE_WORDS = MAX_QUEUES * QUEUE_DEPTH;
  localparam int ADDR_BITS   = QSEL_BITS + PTR_BITS;

  // Fixed field widths of the stream items
  localparam int INDEX_BITS  = 2;
  localparam int VALUE_BITS  = 32;
  localparam int ACTIVE_BITS = 3;
  localparam int IN_DATA_BITS = 40;

  localparam logic [ACTIVE_BITS-1:0] ACTIVE_RESET = 3'd4;

  // Operation codes carried in tuser
  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    logic [PTR_BITS-1:0]   head;
    logic [PTR_BITS-1:0]   tail;
    logic [COUNT_BITS-1:0] count;
  } ptr_entry_t;

  // Advance a slot pointer with wrap at the queue depth
  function automatic logic [PTR_BITS-1:0] next_slot(input logic [PTR_BITS-1:0] p);
    if (p == PTR_BITS'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_BITS'(1);
  endfunction

  // Sign-extend (or truncate) a stored word to the output value width
  function automatic logic [VALUE_BITS-1:0] widen_data(input logic [DATA_BITS-1:0] d);
    logic signed [DATA_BITS-1:0] s;
    s = d;
    return VALUE_BITS'(s);
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/mqf_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mqf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port, holds when not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/mqf_ptr_table.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mqf_ptr_table (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [mqf_pkg::QSEL_BITS-1:0] rd_sel,
  output mqf_pkg::ptr_entry_t                rd_entry,
  input  wire logic                          wr_en,
  input  wire logic [mqf_pkg::QSEL_BITS-1:0] wr_sel,
  input  wire mqf_pkg::ptr_entry_t           wr_entry
);

  mqf_pkg::ptr_entry_t entries [mqf_pkg::MAX_QUEUES];

  // Look up the addressed queue
  assign rd_entry = entries[rd_sel];

  // Write back the updated head, tail and count
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mqf_pkg::MAX_QUEUES; i++) begin
        entries[i] <= '0;
      end
    end else if (wr_en) begin
      entries[wr_sel] <= wr_entry;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/multi_queue_fifo_engine_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Fields (lowest bit up)                      Accept
// s_*       in   tuser: kind; tdata: queue_index, value      s_tvalid & s_tready
// m_*       out  tuser: status; tdata: read_value            m_tvalid & m_tready
// cfg_*     in   cfg_wr_data: active_queues                  cfg_wr_en
//
// One item is accepted per cycle while s_tready is high. Its result passes
// through the read stage and then the output register; a pop reads the shared
// store through its registered read port. Pointers and counts live in
// flip-flops and are updated at acceptance, so the next item sees them at once.
// Reset clears pointers and counts; the store itself is not cleared.
// With the output stalled, one more item is taken into the read stage and
// then s_tready drops until the output register drains.

module multi_queue_fifo_engine_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [mqf_pkg::IN_DATA_BITS-1:0]    s_tdata,  // queue_index, value, zero pad
  input  wire logic                                s_tuser,  // kind
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic      [mqf_pkg::VALUE_BITS-1:0]      m_tdata,  // read_value
  output logic      [1:0]                          m_tuser,  // status
  input  wire logic                                cfg_wr_en,
  input  wire logic [mqf_pkg::ACTIVE_BITS-1:0]     cfg_wr_data
);

  logic [mqf_pkg::ACTIVE_BITS-1:0] active_queues;

  logic [mqf_pkg::INDEX_BITS-1:0] queue_index;
  logic [mqf_pkg::VALUE_BITS-1:0] in_value;
  logic                           kind;
  logic [mqf_pkg::QSEL_BITS-1:0]  qsel;

  mqf_pkg::ptr_entry_t cur_entry;
  mqf_pkg::ptr_entry_t upd_entry;
  logic                upd_en;
  mqf_pkg::status_t    step_status;
  logic                push_ok;
  logic                pop_ok;
  logic                accept;
  logic                advance;
  logic                index_ok;

  logic                pend_valid;
  logic                pend_read;
  mqf_pkg::status_t    pend_status;

  logic                out_valid;
  mqf_pkg::status_t    out_status;
  logic [mqf_pkg::VALUE_BITS-1:0] out_value;

  logic [mqf_pkg::DATA_BITS-1:0]  rd_data;
  logic [mqf_pkg::ADDR_BITS-1:0]  ram_addr;

  // Unpack the input item
  assign queue_index = s_tdata[1:0];
  assign in_value    = s_tdata[33:2];
  assign kind        = s_tuser;
  assign qsel        = mqf_pkg::QSEL_BITS'(queue_index);

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      active_queues <= mqf_pkg::ACTIVE_RESET;
    end else if (cfg_wr_en) begin
      active_queues <= cfg_wr_data;
    end
  end

  mqf_ptr_table u_ptr_table (
    .clk      (clk),
    .rst      (rst),
    .rd_sel   (qsel),
    .rd_entry (cur_entry),
    .wr_en    (upd_en),
    .wr_sel   (qsel),
    .wr_entry (upd_entry)
  );

  // Handshake: read stage moves on when the output register is free
  assign advance  = pend_valid && (!out_valid || m_tready);
  assign s_tready = !pend_valid || advance;
  assign accept   = s_tvalid && s_tready;

  // Decide the operation and its pointer update
  always_comb begin
    index_ok = ({1'b0, queue_index} < active_queues) &&
               (32'(queue_index) < 32'(mqf_pkg::MAX_QUEUES));
    push_ok     = 1'b0;
    pop_ok      = 1'b0;
    step_status = mqf_pkg::ST_OK;
    upd_entry   = cur_entry;
    if (!index_ok) begin
      step_status = mqf_pkg::ST_BAD_INDEX;
    end else if (kind == mqf_pkg::KIND_PUSH) begin
      if (cur_entry.count >= mqf_pkg::COUNT_BITS'(mqf_pkg::QUEUE_DEPTH)) begin
        step_status = mqf_pkg::ST_FULL;
      end else begin
        push_ok         = 1'b1;
        upd_entry.tail  = mqf_pkg::next_slot(cur_entry.tail);
        upd_entry.count = cur_entry.count + mqf_pkg::COUNT_BITS'(1);
      end
    end else begin
      if (cur_entry.count == '0) begin
        step_status = mqf_pkg::ST_EMPTY;
      end else begin
        pop_ok          = 1'b1;
        upd_entry.head  = mqf_pkg::next_slot(cur_entry.head);
        upd_entry.count = cur_entry.count - mqf_pkg::COUNT_BITS'(1);
      end
    end
  end

  assign upd_en   = accept && (push_ok || pop_ok);
  assign ram_addr = push_ok ? {qsel, cur_entry.tail} : {qsel, cur_entry.head};

  mqf_ram #(
    .WIDTH (mqf_pkg::DATA_BITS),
    .DEPTH (mqf_pkg::STORE_WORDS)
  ) u_store (
    .clk     (clk),
    .wr_en   (accept && push_ok),
    .wr_addr (ram_addr),
    .wr_data (mqf_pkg::DATA_BITS'($signed(in_value))),
    .rd_en   (accept && pop_ok),
    .rd_addr (ram_addr),
    .rd_data (rd_data)
  );

  // Read stage: hold status while the store read completes
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (accept) begin
      pend_valid <= 1'b1;
    end else if (advance) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_read   <= pop_ok;
      pend_status <= step_status;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_status <= pend_status;
      out_value  <= pend_read ? mqf_pkg::widen_data(rd_data) : '0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_value;
  assign m_tuser  = out_status;

endmodule

`default_nettype wire
